// ----- rtl/bdcc_pkg.sv -----
// Shared types and constants of the button debounce and click classifier.
package bdcc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned WinW = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FifoDepth = 4;

  localparam logic [CountW-1:0] ClickMax = 4'd15;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NORM_CLOSED = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_EVENTS_EN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_WIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LONG_WIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_WIN = 3'd5;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_CLICKED  = 3'd3,
    EV_DOUBLE   = 3'd4,
    EV_REPEAT   = 3'd5,
    EV_LONG     = 3'd6
  } bdcc_event_e;

  typedef struct packed {
    logic            active_low_wiring;
    logic            normally_closed;
    logic            events_enabled;
    logic [WinW-1:0] debounce_window;
    logic [WinW-1:0] long_press_window;
    logic [WinW-1:0] repeat_click_window;
  } cfg_t;

  typedef struct packed {
    logic              previous_level;
    logic              is_debounced;
    logic [TimeW-1:0]  change_time;
    logic [TimeW-1:0]  press_time;
    logic [TimeW-1:0]  release_time;
    logic [CountW-1:0] click_count;
  } state_t;

  typedef struct packed {
    logic        pressed_level;
    bdcc_event_e event_code;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic    push;
    logic    push2;
    result_t first;
    result_t second;
  } push_t;

endpackage

// ----- rtl/bdcc_if.sv -----
// Valid/ready channel interfaces for pin samples and classified results.
interface bdcc_in_if;
  import bdcc_pkg::*;
  logic             valid;
  logic             ready;
  logic             pin_level;
  logic [TimeW-1:0] now_ticks;

  modport source (output valid, output pin_level, output now_ticks, input ready);
  modport sink (input valid, input pin_level, input now_ticks, output ready);
endinterface

interface bdcc_out_if;
  logic       valid;
  logic       ready;
  logic       pressed_level;
  logic [2:0] event_code;
  logic       last_result;

  modport source (output valid, output pressed_level, output event_code,
                  output last_result, input ready);
  modport sink (input valid, input pressed_level, input event_code,
                input last_result, output ready);
endinterface

// ----- rtl/bdcc_classify.sv -----
// Debounce update and click classification for one registered pin sample.
module bdcc_classify
  import bdcc_pkg::*;
(
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic             pin_level_i,
  input  logic [TimeW-1:0] now_ticks_i,
  output state_t           state_d_o,
  output push_t            push_o
);

  logic             level;
  logic [TimeW-1:0] dt_change;
  logic [TimeW-1:0] dt_press;
  logic [1:0]       n_ev;
  bdcc_event_e      ev0;
  bdcc_event_e      ev1;
  state_t           st;

  assign level     = pin_level_i ^ cfg_i.active_low_wiring ^ cfg_i.normally_closed;
  assign dt_change = now_ticks_i - state_i.change_time;
  assign dt_press  = now_ticks_i - state_i.press_time;

  always_comb begin
    st   = state_i;
    ev0  = EV_NONE;
    ev1  = EV_NONE;
    n_ev = 2'd0;
    if (cfg_i.events_enabled) begin
      if (level == state_i.previous_level) begin
        if (!state_i.is_debounced && (dt_change > {16'd0, cfg_i.debounce_window})) begin
          st.is_debounced = 1'b1;
        end
      end else begin
        st.previous_level = level;
        st.change_time    = now_ticks_i;
        st.is_debounced   = 1'b0;
      end
      if (st.is_debounced) begin
        if (level) begin
          if (state_i.press_time <= state_i.release_time) begin
            st.press_time   = now_ticks_i;
            st.release_time = '0;
            ev0  = EV_PRESSED;
            n_ev = 2'd1;
            if (state_i.click_count < ClickMax) begin
              st.click_count = state_i.click_count + 4'd1;
            end
          end else if ((state_i.click_count != '0) &&
                       (dt_press > {16'd0, cfg_i.long_press_window})) begin
            if (state_i.click_count == 4'd2) begin
              ev0  = EV_CLICKED;
              ev1  = EV_LONG;
              n_ev = 2'd2;
            end else if (state_i.click_count == 4'd3) begin
              ev0  = EV_DOUBLE;
              ev1  = EV_LONG;
              n_ev = 2'd2;
            end else begin
              ev0  = EV_LONG;
              n_ev = 2'd1;
            end
            st.click_count = '0;
          end
        end else begin
          if (state_i.press_time > state_i.release_time) begin
            st.release_time = now_ticks_i;
            ev0 = EV_RELEASED;
            if (state_i.click_count > 4'd2) begin
              ev1  = EV_REPEAT;
              n_ev = 2'd2;
            end else begin
              n_ev = 2'd1;
            end
          end else if ((state_i.click_count != '0) &&
                       (dt_press > {16'd0, cfg_i.repeat_click_window})) begin
            if (state_i.click_count == 4'd1) begin
              ev0  = EV_CLICKED;
              n_ev = 2'd1;
            end else if (state_i.click_count == 4'd2) begin
              ev0  = EV_DOUBLE;
              n_ev = 2'd1;
            end
            st.click_count = '0;
          end
        end
      end
    end
  end

  assign state_d_o = st;

  always_comb begin
    push_o.push                = 1'b1;
    push_o.push2               = (n_ev == 2'd2);
    push_o.first.pressed_level = level;
    push_o.first.event_code    = ev0;
    push_o.first.last_result   = (n_ev != 2'd2);
    push_o.second.pressed_level = level;
    push_o.second.event_code    = ev1;
    push_o.second.last_result   = 1'b1;
  end

endmodule

// ----- rtl/bdcc_out_fifo.sv -----
// Result queue that takes one or two results per cycle and drives the output channel.
module bdcc_out_fifo
  import bdcc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  push_t                        push_i,
  output logic [$clog2(FifoDepth):0]   count_o,
  bdcc_out_if.source                   out_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  result_t             mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  logic                pop;
  logic [PtrW-1:0]     wr_next;
  result_t             head;

  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wr_q + 1'b1;
  assign head    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.push) begin
      wr_d  = push_i.push2 ? PtrW'(wr_q + 2'd2) : wr_next;
      cnt_d = cnt_d + (push_i.push2 ? (PtrW+1)'(2) : (PtrW+1)'(1));
    end
    if (pop) begin
      rd_d  = rd_q + 1'b1;
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.first;
      if (push_i.push2) begin
        mem_q[wr_next] <= push_i.second;
      end
    end
  end

  assign count_o             = cnt_q;
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.pressed_level = head.pressed_level;
  assign out_o.event_code    = head.event_code;
  assign out_o.last_result   = head.last_result;

endmodule

// ----- rtl/button_debounce_click_classifier.sv -----
// Top level of the button debounce and click classifier.
//
// Usage: one pin sample with its 32-bit timestamp enters per transaction on
// the input channel. Each sample gives one or two result transactions on the
// output channel; only the final one of a sample has last_result set, and a
// sample that raises no event gives one result with event code none.
// An accepted sample passes through the input register and then the result
// queue before its first result is offered. Throughput is one sample per
// cycle while each gives one result and the receiver does not stall; the
// two results of a sample leave one at a time through the single read port
// of the four-entry result queue. The user must write configuration registers
// through the write port only while the block is idle; the block itself does
// not enforce this. A write takes effect for the next sample. Reset clears
// the debounce and click state, empties the queue and loads the default
// configuration. When the receiver stalls, results wait in the queue; the
// input register holds its sample, refusing input, while fewer than two
// queue entries are free.
module button_debounce_click_classifier
  import bdcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WinW-1:0]    cfg_data_i,
  bdcc_in_if.sink            in_i,
  bdcc_out_if.source         out_o
);

  cfg_t                        cfg_q;
  state_t                      state_q, state_d;
  logic                        s1_valid_q;
  logic                        s1_pin_q;
  logic [TimeW-1:0]            s1_now_q;
  logic [$clog2(FifoDepth):0]  fifo_cnt;
  logic                        advance;
  push_t                       push_raw;
  push_t                       push;

  assign advance    = s1_valid_q && (fifo_cnt <= ($clog2(FifoDepth)+1)'(FifoDepth - 2));
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low_wiring   <= 1'b0;
      cfg_q.normally_closed     <= 1'b0;
      cfg_q.events_enabled      <= 1'b1;
      cfg_q.debounce_window     <= 16'd50;
      cfg_q.long_press_window   <= 16'd1000;
      cfg_q.repeat_click_window <= 16'd300;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_LOW:   cfg_q.active_low_wiring   <= cfg_data_i[0];
        CFG_NORM_CLOSED:  cfg_q.normally_closed     <= cfg_data_i[0];
        CFG_EVENTS_EN:    cfg_q.events_enabled      <= cfg_data_i[0];
        CFG_DEBOUNCE_WIN: cfg_q.debounce_window     <= cfg_data_i;
        CFG_LONG_WIN:     cfg_q.long_press_window   <= cfg_data_i;
        CFG_REPEAT_WIN:   cfg_q.repeat_click_window <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_pin_q <= in_i.pin_level;
      s1_now_q <= in_i.now_ticks;
    end
  end

  bdcc_classify u_classify (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .pin_level_i (s1_pin_q),
    .now_ticks_i (s1_now_q),
    .state_d_o   (state_d),
    .push_o      (push_raw)
  );

  always_comb begin
    push       = push_raw;
    push.push  = advance;
    push.push2 = advance && push_raw.push2;
  end

  bdcc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .count_o (fifo_cnt),
    .out_o   (out_o)
  );

endmodule

// ----- rtl/bdcc_checker.sv -----
// Port-level assertions for the button debounce and click classifier, bound to the top level.
module bdcc_checker
  import bdcc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_level_i,
  input logic [2:0] out_code_i,
  input logic       out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("A stalled result transaction was withdrawn.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_level_i) && $stable(out_code_i) && $stable(out_last_i))
    else $error("A stalled result transaction changed its payload.");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_code_i != 3'd7))
    else $error("A result carries an undefined event code.");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_code_i == EV_NONE) |-> out_last_i)
    else $error("A result without an event is not the final result of its sample.");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_last_i &&
      (out_level_i == $past(out_level_i)))
    else $error("The first of two results is not followed by its partner.");

endmodule

bind button_debounce_click_classifier bdcc_checker u_bdcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_level_i (out_o.pressed_level),
  .out_code_i  (out_o.event_code),
  .out_last_i  (out_o.last_result)
);
